// ===== hw/rtl/pbnel_pkg.sv =====
package pbnel_pkg;

  // page geometry
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_AW    = $clog2(PAGE_BYTES);
  // walk positions can run past the page by a key length plus a trailer
  localparam int POS_W      = 17;

  localparam logic [POS_W-1:0] POS_DATA_BASE = POS_W'(16);
  localparam logic [POS_W-1:0] POS_LEN_BYTES = POS_W'(2);
  localparam logic [POS_W-1:0] POS_RID_BYTES = POS_W'(8);
  localparam logic [POS_W-1:0] POS_CHILD_BYTES = POS_W'(4);
  localparam logic [POS_W-1:0] POS_PAGE_END = POS_W'(PAGE_BYTES);

  // command codes
  localparam logic [2:0] CMD_WRITE_BYTE = 3'd0;
  localparam logic [2:0] CMD_READ_BYTE  = 3'd1;
  localparam logic [2:0] CMD_LOCATE     = 3'd2;
  localparam logic [2:0] CMD_GET_CHILD  = 3'd3;
  localparam logic [2:0] CMD_SET_RID    = 3'd4;
  localparam logic [2:0] CMD_SET_CHILD  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_KIND  = 2'd2;
  localparam logic [1:0] ST_PAST  = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] byte_address;
    logic [7:0]  byte_data;
    logic [15:0] entry_index;
    logic [63:0] word_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] key_offset;
    logic [15:0] key_length;
    logic [63:0] value;
  } out_item_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [PAGE_AW-1:0] addr;
    logic [7:0]         wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/pbnel_page_mem.sv =====
module pbnel_page_mem import pbnel_pkg::*; (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] store_r [PAGE_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      store_r[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= store_r[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pbnel_walker.sv =====
module pbnel_walker import pbnel_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  in_item_t   item,
  output logic       idle,
  output logic       res_valid,
  input  logic       res_take,
  output out_item_t  res,
  output mem_req_t   mem_req,
  input  logic [7:0] mem_rdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HDR   = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_LEN   = 4'd4;
  localparam logic [3:0] S_FOUND = 4'd5;
  localparam logic [3:0] S_CHILD = 4'd6;
  localparam logic [3:0] S_TAIL  = 4'd7;
  localparam logic [3:0] S_STORE = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]         state_r;
  logic [2:0]         cmd_r;
  logic [15:0]        idx_r;
  logic [63:0]        word_r;
  logic               leaf_r;
  logic [15:0]        nkeys_r;
  logic [POS_W-1:0]   p_r;
  logic [POS_W-1:0]   cpos_r;
  logic [15:0]        k_r;
  logic [15:0]        tgt_r;
  logic [15:0]        len_r;
  logic [PAGE_AW-1:0] f_base_r;
  logic [3:0]         f_n_r;
  logic [3:0]         f_iss_r;
  logic [3:0]         f_rcv_r;
  logic [63:0]        acc_r;
  logic [63:0]        acc_nxt;
  logic               rvalid_r;
  logic [1:0]         st_r;
  logic [11:0]        koff_r;
  logic [15:0]        klen_r;
  logic [63:0]        val_r;

  logic               fetching;
  logic               fetch_done;
  logic               acc_clr;
  logic [POS_W-1:0]   trail;
  logic [POS_W-1:0]   adv_pos;
  logic [POS_W-1:0]   key_start;
  logic [POS_W-1:0]   key_end;
  logic [POS_W-1:0]   need_end;

  assign fetching = (state_r == S_HDR) || (state_r == S_LEN) || (state_r == S_TAIL);

  always_comb begin
    mem_req.re    = fetching && (f_iss_r < f_n_r);
    mem_req.we    = (state_r == S_STORE);
    mem_req.addr  = f_base_r + PAGE_AW'(f_iss_r);
    mem_req.wdata = word_r[{f_iss_r[2:0], 3'b000} +: 8];
  end

  // gather restarts in the states that precede a fetch
  assign acc_clr = (state_r == S_IDLE) || (state_r == S_CHK) ||
                   (state_r == S_FOUND) || (state_r == S_CHILD);

  // little-endian gather of returned bytes
  always_comb begin
    acc_nxt = acc_r;
    if (acc_clr) begin
      acc_nxt = '0;
    end else if (rvalid_r) begin
      acc_nxt[{f_rcv_r[2:0], 3'b000} +: 8] = mem_rdata;
    end
  end

  assign fetch_done = rvalid_r && (f_rcv_r == f_n_r - 4'd1);
  assign trail      = leaf_r ? POS_RID_BYTES : POS_CHILD_BYTES;
  assign adv_pos    = p_r + POS_LEN_BYTES + POS_W'(acc_nxt[15:0]) + trail;
  assign key_start  = p_r + POS_LEN_BYTES;
  assign key_end    = key_start + POS_W'(len_r);
  assign need_end   = key_end + (leaf_r ? POS_RID_BYTES : POS_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= mem_req.re;
      acc_r    <= acc_nxt;
      if (mem_req.re || mem_req.we) begin
        f_iss_r <= f_iss_r + 4'd1;
      end
      if (rvalid_r) begin
        f_rcv_r <= f_rcv_r + 4'd1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= item.command;
            idx_r   <= item.entry_index;
            word_r  <= (item.command == CMD_WRITE_BYTE) ? {56'b0, item.byte_data} :
                       item.word_data;
            st_r    <= ST_OK;
            koff_r  <= '0;
            klen_r  <= '0;
            val_r   <= '0;
            f_iss_r <= '0;
            f_rcv_r <= '0;
            case (item.command) inside
              CMD_WRITE_BYTE: begin
                f_base_r <= item.byte_address;
                f_n_r    <= 4'd1;
                state_r  <= S_STORE;
              end
              CMD_READ_BYTE: begin
                f_base_r <= item.byte_address;
                f_n_r    <= 4'd1;
                state_r  <= S_TAIL;
              end
              CMD_LOCATE, CMD_GET_CHILD, CMD_SET_RID, CMD_SET_CHILD: begin
                f_base_r <= '0;
                f_n_r    <= 4'd3;
                state_r  <= S_HDR;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_HDR: begin
          if (fetch_done) begin
            leaf_r  <= (acc_nxt[7:0] != 8'd0);
            nkeys_r <= acc_nxt[23:8];
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          k_r <= '0;
          case (cmd_r) inside
            CMD_LOCATE, CMD_SET_RID: begin
              if (cmd_r == CMD_SET_RID && !leaf_r) begin
                st_r    <= ST_KIND;
                state_r <= S_DONE;
              end else if (idx_r >= nkeys_r) begin
                st_r    <= ST_RANGE;
                state_r <= S_DONE;
              end else begin
                tgt_r   <= idx_r;
                p_r     <= leaf_r ? POS_DATA_BASE : POS_DATA_BASE + POS_CHILD_BYTES;
                state_r <= S_CHK;
              end
            end
            CMD_GET_CHILD, CMD_SET_CHILD: begin
              if (leaf_r) begin
                st_r    <= ST_KIND;
                state_r <= S_DONE;
              end else if (idx_r == 16'd0) begin
                cpos_r  <= POS_DATA_BASE;
                state_r <= S_CHILD;
              end else if (idx_r > nkeys_r) begin
                st_r    <= ST_RANGE;
                state_r <= S_DONE;
              end else begin
                tgt_r   <= idx_r - 16'd1;
                p_r     <= POS_DATA_BASE + POS_CHILD_BYTES;
                state_r <= S_CHK;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_CHK: begin
          if (p_r > POS_PAGE_END - POS_LEN_BYTES) begin
            st_r    <= ST_PAST;
            state_r <= S_DONE;
          end else begin
            f_base_r <= p_r[PAGE_AW-1:0];
            f_n_r    <= 4'd2;
            f_iss_r  <= '0;
            f_rcv_r  <= '0;
            state_r  <= S_LEN;
          end
        end
        S_LEN: begin
          if (fetch_done) begin
            if (k_r == tgt_r) begin
              len_r   <= acc_nxt[15:0];
              state_r <= S_FOUND;
            end else begin
              p_r     <= adv_pos;
              k_r     <= k_r + 16'd1;
              state_r <= S_CHK;
            end
          end
        end
        S_FOUND: begin
          f_iss_r <= '0;
          f_rcv_r <= '0;
          case (cmd_r) inside
            CMD_LOCATE, CMD_SET_RID: begin
              if (need_end > POS_PAGE_END) begin
                st_r    <= ST_PAST;
                state_r <= S_DONE;
              end else if (cmd_r == CMD_SET_RID) begin
                f_base_r <= key_end[PAGE_AW-1:0];
                f_n_r    <= 4'd8;
                state_r  <= S_STORE;
              end else begin
                koff_r <= key_start[11:0];
                klen_r <= len_r;
                if (leaf_r) begin
                  f_base_r <= key_end[PAGE_AW-1:0];
                  f_n_r    <= 4'd8;
                  state_r  <= S_TAIL;
                end else begin
                  state_r <= S_DONE;
                end
              end
            end
            default: begin
              cpos_r  <= key_end;
              state_r <= S_CHILD;
            end
          endcase
        end
        S_CHILD: begin
          f_iss_r <= '0;
          f_rcv_r <= '0;
          if (cpos_r + POS_CHILD_BYTES > POS_PAGE_END) begin
            st_r    <= ST_PAST;
            state_r <= S_DONE;
          end else begin
            f_base_r <= cpos_r[PAGE_AW-1:0];
            f_n_r    <= 4'd4;
            state_r  <= (cmd_r == CMD_GET_CHILD) ? S_TAIL : S_STORE;
          end
        end
        S_TAIL: begin
          if (fetch_done) begin
            val_r   <= acc_nxt;
            state_r <= S_DONE;
          end
        end
        S_STORE: begin
          if (f_iss_r == f_n_r - 4'd1) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle       = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.status     = st_r;
  assign res.key_offset = koff_r;
  assign res.key_length = klen_r;
  assign res.value      = val_r;

endmodule

// ===== hw/rtl/packed_btree_node_entry_locator.sv =====
// Index page entry locator. The block keeps one 4096-byte index page in a
// single-port byte memory and works on one command at a time; every accepted
// command gives exactly one result. Locate, get child, set rid and set
// child first read the 3-byte header, then walk the packed entries one
// length field at a time, and end with up to 8 trailer bytes read or
// written one per cycle. The single memory port is shared by the header
// read, the walk and the trailer access.
// The page is undefined after reset: read only bytes that were written.
// A finished result sits in an output register, so the next command is
// taken while the previous result still waits on out_stall.
module packed_btree_node_entry_locator import pbnel_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  // command channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       walk_idle;
  logic       res_valid;
  logic       res_take;
  out_item_t  res;
  logic       out_valid_r;
  out_item_t  out_item_r;

  // page byte store
  pbnel_page_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // command sequencer and entry walk
  pbnel_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && walk_idle),
    .item      (in_item),
    .idle      (walk_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // a command transfer happens only while the sequencer is idle
  assign in_stall = !walk_idle;

  // output register refills on the cycle its content is transferred
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
